### src/spts_pkg.sv
`timescale 1ns / 1ps

package spts_pkg;

   // Canvas and tile geometry
   localparam int TILE_EDGE    = 64;
   localparam int MAX_WIDTH    = 512;
   localparam int MAX_HEIGHT   = 512;
   localparam int TILE_SHIFT   = $clog2(TILE_EDGE);
   localparam int TILES_X_MAX  = (MAX_WIDTH + TILE_EDGE - 1) / TILE_EDGE;
   localparam int TILES_Y_MAX  = (MAX_HEIGHT + TILE_EDGE - 1) / TILE_EDGE;
   localparam int TILE_COUNT   = TILES_X_MAX * TILES_Y_MAX;
   localparam int TILE_BITS    = $clog2(TILE_COUNT);
   localparam int LOCAL_BITS   = 2 * TILE_SHIFT;
   localparam int ADDR_W       = TILE_BITS + LOCAL_BITS;
   localparam int XB           = $clog2(MAX_WIDTH);
   localparam int YB           = $clog2(MAX_HEIGHT);
   localparam int TX_BITS      = XB - TILE_SHIFT;
   localparam int TY_BITS      = YB - TILE_SHIFT;
   localparam int TXC_BITS     = $clog2(TILES_X_MAX + 1);
   localparam int TS_BITS      = TY_BITS + TXC_BITS + 1;

   // Field widths
   localparam int CMD_W        = 2;
   localparam int COORD_W      = 11;
   localparam int CHAN_W       = 8;
   localparam int PIX_W        = 4 * CHAN_W;
   localparam int CFG_W        = 10;
   localparam int CSR_IDX_W    = 1;
   localparam int REQ_W        = 56;
   localparam int RSP_W        = PIX_W;

   // Request payload layout
   localparam int X_LSB        = CMD_W;
   localparam int Y_LSB        = X_LSB + COORD_W;
   localparam int COLOUR_LSB   = Y_LSB + COORD_W;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(512);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(512);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_idx_type;

   // Controller to datapath
   typedef struct packed {
      logic use_req;      // address and colour from the request port
      logic latch;        // capture request coordinates and colour
      logic fill_start;   // capture colour, park at the canvas origin
      logic fill_step;    // advance raster position
      logic mem_wr;       // write colour at current pixel
      logic mem_rd;       // read current pixel
      logic zero_start;   // rewind tile sweep counter
      logic zero_step;    // write zero, advance sweep
      logic set_present;  // mark current tile present
      logic clear_all;    // drop every present bit
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      cmd_type req_cmd;
      logic    req_inb;
      logic    tile_ok;
      logic    present;
      logic    zero_last;
      logic    last_col;
      logic    last_row;
      logic    empty;
      logic    rsp_free;
   } dp_sts_type;

endpackage

### src/spts_ctrl.sv
`timescale 1ns / 1ps

module spts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  spts_pkg::dp_sts_type sts,
   output spts_pkg::dp_cmd_type cmd
);
   import spts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ZERO,
      ST_PIX_WR,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;
   logic      fill_ff, fill_in;
   logic      accept;

   assign req_tready = !reset && (state_ff == ST_IDLE) && sts.rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      fill_in  = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.use_req = 1'b1;
            if (accept) begin
               case (sts.req_cmd)
                  CMD_WRITE: begin
                     if (sts.req_inb && sts.tile_ok) begin
                        if (sts.present) begin
                           cmd.mem_wr = 1'b1;
                        end else begin
                           cmd.latch      = 1'b1;
                           cmd.zero_start = 1'b1;
                           fill_in        = 1'b0;
                           state_in       = ST_ZERO;
                        end
                     end
                  end
                  CMD_READ: begin
                     cmd.mem_rd = 1'b1;
                  end
                  CMD_FILL: begin
                     cmd.fill_start = 1'b1;
                     if (!sts.empty) begin
                        state_in = ST_FILL;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.clear_all = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ZERO: begin
            cmd.zero_step = 1'b1;
            if (sts.zero_last) begin
               cmd.set_present = 1'b1;
               state_in        = fill_ff ? ST_FILL : ST_PIX_WR;
            end
         end
         ST_PIX_WR: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FILL: begin
            if (sts.tile_ok && !sts.present) begin
               cmd.zero_start = 1'b1;
               fill_in        = 1'b1;
               state_in       = ST_ZERO;
            end else begin
               cmd.mem_wr    = sts.tile_ok;
               cmd.fill_step = 1'b1;
               if (sts.last_col && sts.last_row) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

### src/spts_datapath.sv
`timescale 1ns / 1ps

module spts_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [spts_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [spts_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [spts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spts_pkg::CFG_W-1:0]       csr_wdata,
   input  spts_pkg::dp_cmd_type             cmd,
   output spts_pkg::dp_sts_type             sts
);
   import spts_pkg::*;

   logic [CFG_W-1:0]      width_ff, height_ff;
   logic [CFG_W-1:0]      eff_w, eff_h;
   logic [CFG_W:0]        tiles_x_wide;
   logic [TXC_BITS-1:0]   tiles_x;

   logic signed [COORD_W-1:0] req_x, req_y;
   logic [PIX_W-1:0]      req_colour;
   logic                  req_inb;

   logic [XB-1:0]         x_ff, cur_x;
   logic [YB-1:0]         y_ff, cur_y;
   logic [PIX_W-1:0]      colour_ff, cur_colour;
   logic [LOCAL_BITS-1:0] zcnt_ff;

   logic [TX_BITS-1:0]    tx;
   logic [TY_BITS-1:0]    ty;
   logic [TS_BITS-1:0]    tile_sum;
   logic [TILE_BITS-1:0]  tile_idx;
   logic                  tile_ok;
   logic [ADDR_W-1:0]     mem_addr;
   logic [PIX_W-1:0]      mem_wdata;
   logic                  mem_we;

   logic [TILE_COUNT-1:0] present_ff;
   logic [PIX_W-1:0]      mem [0:(1 << ADDR_W) - 1];
   logic [PIX_W-1:0]      rd_data_ff;
   logic                  rd_pend_ff, hit_ff;
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff;

   // Size registers; eff_w and eff_h below clamp them to the canvas limits
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_w = (width_ff > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_ff;
   assign eff_h = (height_ff > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_ff;
   assign tiles_x_wide = ((CFG_W+1)'(eff_w) + (CFG_W+1)'(TILE_EDGE - 1)) >> TILE_SHIFT;
   assign tiles_x = tiles_x_wide[TXC_BITS-1:0];

   // Request fields
   assign req_x      = req_tdata[X_LSB +: COORD_W];
   assign req_y      = req_tdata[Y_LSB +: COORD_W];
   assign req_colour = req_tdata[COLOUR_LSB +: PIX_W];
   assign req_inb    = !req_x[COORD_W-1] && !req_y[COORD_W-1]
                       && (req_x[CFG_W-1:0] < eff_w) && (req_y[CFG_W-1:0] < eff_h);

   assign cur_x      = cmd.use_req ? req_x[XB-1:0] : x_ff;
   assign cur_y      = cmd.use_req ? req_y[YB-1:0] : y_ff;
   assign cur_colour = cmd.use_req ? req_colour : colour_ff;

   // Tile lookup
   assign tx       = cur_x[XB-1:TILE_SHIFT];
   assign ty       = cur_y[YB-1:TILE_SHIFT];
   assign tile_sum = TS_BITS'(ty) * TS_BITS'(tiles_x) + TS_BITS'(tx);
   assign tile_ok  = tile_sum < TS_BITS'(TILE_COUNT);
   assign tile_idx = tile_sum[TILE_BITS-1:0];

   assign mem_addr  = cmd.zero_step
                      ? {tile_idx, zcnt_ff}
                      : {tile_idx, cur_y[TILE_SHIFT-1:0], cur_x[TILE_SHIFT-1:0]};
   assign mem_wdata = cmd.zero_step ? '0 : cur_colour;
   assign mem_we    = cmd.zero_step || cmd.mem_wr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (cmd.clear_all) begin
         present_ff <= '0;
      end else if (cmd.set_present) begin
         present_ff[tile_idx] <= 1'b1;
      end
   end

   // Held coordinates, colour and sweep counter
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x_ff      <= req_x[XB-1:0];
         y_ff      <= req_y[YB-1:0];
         colour_ff <= req_colour;
      end else if (cmd.fill_start) begin
         x_ff      <= '0;
         y_ff      <= '0;
         colour_ff <= req_colour;
      end else if (cmd.fill_step) begin
         if (sts.last_col) begin
            x_ff <= '0;
            y_ff <= y_ff + YB'(1);
         end else begin
            x_ff <= x_ff + XB'(1);
         end
      end
      if (cmd.zero_start) begin
         zcnt_ff <= '0;
      end else if (cmd.zero_step) begin
         zcnt_ff <= zcnt_ff + LOCAL_BITS'(1);
      end
   end

   // Read response: the RAM read register, then the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.mem_rd;
         if (rd_pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         hit_ff <= req_inb && tile_ok && present_ff[tile_idx];
      end
      if (rd_pend_ff) begin
         rsp_data_ff <= hit_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign sts.req_cmd   = cmd_type'(req_tdata[CMD_W-1:0]);
   assign sts.req_inb   = req_inb;
   assign sts.tile_ok   = tile_ok;
   assign sts.present   = tile_ok && present_ff[tile_idx];
   assign sts.zero_last = &zcnt_ff;
   assign sts.last_col  = CFG_W'(x_ff) == (eff_w - CFG_W'(1));
   assign sts.last_row  = CFG_W'(y_ff) == (eff_h - CFG_W'(1));
   assign sts.empty     = (eff_w == '0) || (eff_h == '0);
   assign sts.rsp_free  = !rd_pend_ff && (!rsp_valid_ff || rsp_tready);

endmodule

### src/sparse_tiled_pixel_store.sv
`timescale 1ns / 1ps
// Pixel read: the result passes the RAM read register, then the response register;
// the next request goes in as the result is taken, later if the result waits.
// Pixel write into a present tile or clear: one request per cycle while no read is held.
// First write into an absent tile: accept, zeroing of all 4096 words of the tile, write.
// Fill: accept, then a raster walk over the canvas that zeroes each absent tile it reaches.
// Reset (synchronous): present bits drop, size returns to 512 x 512, RAM kept.

module sparse_tiled_pixel_store (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[1:0], x_coord[12:2], y_coord[23:13], red[31:24],
   // green[39:32], blue[47:40], alpha[55:48]
   input  logic [spts_pkg::REQ_W-1:0]       req_tdata,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_red[7:0], read_green[15:8], read_blue[23:16], read_alpha[31:24]
   output logic [spts_pkg::RSP_W-1:0]       rsp_tdata,
   // configuration writes: 0 image_width, 1 image_height
   input  logic                             csr_wr_en,
   input  logic [spts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spts_pkg::CFG_W-1:0]       csr_wdata
);
   import spts_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer: reads and present-tile writes issue straight from the idle state,
   // while tile zeroing and canvas fill walk through states of their own.
   spts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: size registers, tile address math, present bits, pixel RAM,
   // and the response register that holds a result until it is taken.
   spts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

### tb/sv/sparse_tiled_pixel_store_tb.sv
`timescale 1ns / 1ps

module sparse_tiled_pixel_store_tb;
   import spts_pkg::*;

   localparam int TILE_PIXELS = TILE_EDGE * TILE_EDGE;

   // One outstanding pixel read: where it looked and what must come back.
   typedef struct {
      int               x;
      int               y;
      logic [PIX_W-1:0] pixel;
   } pixel_read_type;

   // DUT connections; every input starts at a known value.
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en  = 1'b0;
   csr_idx_type          csr_index  = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   // Mirror of the canvas: size registers, present bits and pixel storage.
   logic [CFG_W-1:0]     canvas_w = RESET_WIDTH;
   logic [CFG_W-1:0]     canvas_h = RESET_HEIGHT;
   bit                   tile_live [TILE_COUNT];
   bit [PIX_W-1:0]       canvas_mem [TILE_COUNT * TILE_PIXELS];

   pixel_read_type       pending_reads [$];

   // Run bookkeeping
   bit                   idle_en = 1'b1;
   int unsigned          stall_left;
   int unsigned          error_count;
   int unsigned          requests_sent;
   int unsigned          reads_checked;
   int unsigned          fills_sent;
   int unsigned          clears_sent;
   int unsigned          sizes_used;

   sparse_tiled_pixel_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Canvas predictor
   // ------------------------------------------------------------------

   // Clamp the size registers to the largest canvas the store can hold.
   function automatic int eff_width();
      return (canvas_w > MAX_WIDTH) ? MAX_WIDTH : int'(canvas_w);
   endfunction

   function automatic int eff_height();
      return (canvas_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(canvas_h);
   endfunction

   // Map an in-bounds pixel to its tile and its word in pixel storage, using the
   // tiles-per-row that the current width gives.
   function automatic int locate(int px, int py, output int addr);
      int tiles_x;
      int tile;
      tiles_x = (eff_width() + TILE_EDGE - 1) / TILE_EDGE;
      tile    = (py / TILE_EDGE) * tiles_x + px / TILE_EDGE;
      addr    = tile * TILE_PIXELS + (py % TILE_EDGE) * TILE_EDGE + px % TILE_EDGE;
      return tile;
   endfunction

   // Write one pixel; the first touch of an absent tile zeroes it first.
   function automatic void store_pixel(int px, int py, logic [PIX_W-1:0] colour);
      int tile;
      int addr;
      int k;
      tile = locate(px, py, addr);
      if (tile >= TILE_COUNT)
         return;
      if (!tile_live[tile]) begin
         for (k = 0; k < TILE_PIXELS; k++)
            canvas_mem[tile * TILE_PIXELS + k] = '0;
         tile_live[tile] = 1'b1;
      end
      canvas_mem[addr] = colour;
   endfunction

   // Apply one request to the mirror; a read queues the pixel it must return.
   function automatic void predict_request(cmd_type cmd, int px, int py,
                                           logic [PIX_W-1:0] colour);
      int             w;
      int             h;
      int             tile;
      int             addr;
      int             xx;
      int             yy;
      bit             inb;
      pixel_read_type rd;
      w   = eff_width();
      h   = eff_height();
      inb = px >= 0 && py >= 0 && px < w && py < h;
      case (cmd)
         CMD_WRITE: begin
            if (inb)
               store_pixel(px, py, colour);
         end
         CMD_READ: begin
            rd.x     = px;
            rd.y     = py;
            rd.pixel = '0;
            if (inb) begin
               tile = locate(px, py, addr);
               if (tile < TILE_COUNT && tile_live[tile])
                  rd.pixel = canvas_mem[addr];
            end
            pending_reads.push_back(rd);
         end
         CMD_FILL: begin
            fills_sent++;
            for (yy = 0; yy < h; yy++)
               for (xx = 0; xx < w; xx++)
                  store_pixel(xx, yy, colour);
         end
         default: begin
            // Clear drops present bits only; pixel storage keeps its contents.
            clears_sent++;
            foreach (tile_live[k])
               tile_live[k] = 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Result side: hold tready low for random bursts, which start only while idle_en is set.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one request, hold it until accepted. Enter and leave at a falling
   // edge; tvalid stays high, so requests have no gap unless idle_en adds one.
   task automatic send_request(cmd_type cmd, int x, int y, logic [PIX_W-1:0] colour);
      logic signed [COORD_W-1:0] xs;
      logic signed [COORD_W-1:0] ys;
      xs = COORD_W'(x);
      ys = COORD_W'(y);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      predict_request(cmd, int'(xs), int'(ys), colour);
      req_tdata  <= {colour, ys, xs, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Write one size register; the block must be idle.
   task automatic write_csr(csr_idx_type idx, logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_IMAGE_WIDTH)
         canvas_w = value;
      else
         canvas_h = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_canvas(int w, int h);
      write_csr(CSR_IMAGE_WIDTH, CFG_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CFG_W'(h));
      sizes_used++;
   endtask

   // Bring the block to idle. A trailing read queues behind any fill or tile
   // sweep still running, so its result marks the end of all earlier work.
   task automatic settle_block();
      send_request(CMD_READ, 0, 0, $urandom);
      req_tvalid <= 1'b0;
      while (pending_reads.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      pixel_read_type want;
      bit             bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reads.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("ERROR: result %08h with no read outstanding", rsp_tdata);
         end else begin
            want = pending_reads.pop_front();
            reads_checked++;
            bad = 1'b0;
            // Compare red, green, blue and alpha one channel at a time.
            for (int c = 0; c < 4; c++)
               if (rsp_tdata[c*CHAN_W +: CHAN_W] !== want.pixel[c*CHAN_W +: CHAN_W])
                  bad = 1'b1;
            if (bad) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: read (%0d,%0d) expected r=%02h g=%02h b=%02h a=%02h",
                           want.x, want.y,
                           want.pixel[7:0], want.pixel[15:8],
                           want.pixel[23:16], want.pixel[31:24]);
                  $display("       got r=%02h g=%02h b=%02h a=%02h",
                           rsp_tdata[7:0], rsp_tdata[15:8],
                           rsp_tdata[23:16], rsp_tdata[31:24]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Pick one coordinate against a canvas edge of the given length: mostly a
   // hot region near the origin, some edges and tile seams, some anywhere,
   // and a share out of bounds on both sides.
   function automatic int pick_coord(int limit, int span);
      int roll;
      int hot;
      roll = $urandom_range(0, 99);
      if (limit == 0 || roll < 8) begin
         case ($urandom_range(0, 4))
            0:       return -1;
            1:       return -1024;
            2:       return limit;
            3:       return 1023;
            default: return int'($urandom_range(0, 2047)) - 1024;
         endcase
      end
      if (roll < 25) begin
         case ($urandom_range(0, 3))
            0:       return 0;
            1:       return limit - 1;
            2:       return (limit > 63) ? 63 : limit - 1;
            default: return (limit > 64) ? 64 : limit - 1;
         endcase
      end
      hot = (span < limit) ? span : limit;
      if (roll < 85)
         return $urandom_range(0, hot - 1);
      return $urandom_range(0, limit - 1);
   endfunction

   // One canvas size, then a random mix of writes and reads. Reads often go
   // back to recently written pixels; fills and clears are rare and capped
   // since each can cost whole tile sweeps.
   task automatic run_random_phase(int w, int h, int count, int span,
                                   int fill_budget, int clear_budget);
      int      ew;
      int      eh;
      int      roll;
      int      k;
      int      x;
      int      y;
      cmd_type cmd;
      int      hist_x [$];
      int      hist_y [$];
      set_canvas(w, h);
      ew = eff_width();
      eh = eff_height();
      repeat (count) begin
         roll = $urandom_range(0, 199);
         x    = pick_coord(ew, span);
         y    = pick_coord(eh, span);
         cmd  = CMD_WRITE;
         if (roll < 3 && fill_budget > 0) begin
            cmd = CMD_FILL;
            fill_budget--;
         end else if (roll >= 3 && roll < 6 && clear_budget > 0) begin
            cmd = CMD_CLEAR;
            clear_budget--;
         end else if (roll < 100) begin
            cmd = CMD_READ;
            if (hist_x.size() > 0 && $urandom_range(0, 1) == 1) begin
               k = $urandom_range(0, hist_x.size() - 1);
               x = hist_x[k];
               y = hist_y[k];
            end
         end else begin
            hist_x.push_back(x);
            hist_y.push_back(y);
            if (hist_x.size() > 32) begin
               void'(hist_x.pop_front());
               void'(hist_y.pop_front());
            end
         end
         send_request(cmd, x, y, $urandom);
      end
      settle_block();
   endtask

   // Pixel access at the reset size: absent tiles, first-touch zeroing, both
   // canvas corners, out-of-bounds writes and reads, and clear.
   task automatic test_basic_access();
      send_request(CMD_READ, 0, 0, '0);               // absent tile reads zero
      send_request(CMD_WRITE, 0, 0, 32'h00FF_00FF);
      send_request(CMD_READ, 0, 0, '0);
      send_request(CMD_READ, 63, 63, '0);             // rest of tile was zeroed
      send_request(CMD_WRITE, 511, 511, 32'hFF00_FF00);
      send_request(CMD_READ, 511, 511, '0);
      // Writes off the canvas on every side must not land anywhere.
      send_request(CMD_WRITE, -1, 0, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 512, 0, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 0, -1024, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, 1023, 1023, 32'hFFFF_FFFF);
      send_request(CMD_READ, -1, 0, '0);
      send_request(CMD_READ, 1023, 1023, '0);
      send_request(CMD_READ, -1024, 511, '0);
      send_request(CMD_READ, 511, 512, '0);
      send_request(CMD_READ, 0, 0, '0);
      // Clear, then the next write must re-zero the tile despite old contents.
      send_request(CMD_CLEAR, 0, 0, '0);
      send_request(CMD_READ, 0, 0, '0);
      send_request(CMD_WRITE, 1, 0, 32'h1234_5678);
      send_request(CMD_READ, 0, 0, '0);
      send_request(CMD_READ, 1, 0, '0);
      settle_block();
   endtask

   // Size register extremes: zero size, oversized width, a single pixel.
   // Drain the block before each size change.
   task automatic test_size_extremes();
      set_canvas(0, 0);
      send_request(CMD_FILL, 0, 0, 32'hA5A5_A5A5);     // nothing in bounds
      send_request(CMD_READ, 0, 0, '0);
      settle_block();
      set_canvas(1023, 1);                            // width clamps to 512
      send_request(CMD_FILL, 0, 0, 32'h5A3C_C3A5);
      send_request(CMD_READ, 511, 0, '0);
      send_request(CMD_READ, 512, 0, '0);
      send_request(CMD_READ, 0, 1, '0);
      settle_block();
      set_canvas(1, 1);
      send_request(CMD_WRITE, 0, 0, 32'hFFFF_FFFF);
      send_request(CMD_READ, 0, 0, '0);
      settle_block();
   endtask

   // Random traffic over a range of sizes; present tiles carry over each
   // size change, so later phases read them through a new tile mapping.
   task automatic test_random_traffic();
      run_random_phase(64, 64, 220, 16, 3, 3);        // exactly one tile
      run_random_phase(130, 70, 220, 80, 2, 2);       // partial tiles on both edges
      run_random_phase(1, 512, 160, 100, 2, 2);       // one column through 8 tiles
      run_random_phase(512, 512, 260, 128, 0, 0);     // full canvas, no fills
      run_random_phase(1023, 1023, 120, 128, 0, 0);   // oversized, clamps to 512
      run_random_phase(200, 0, 40, 64, 1, 1);         // zero height
   endtask

   // Last stretch at full rate on both sides.
   task automatic test_quiet_tail();
      idle_en = 1'b0;
      run_random_phase(100, 100, 300, 50, 2, 2);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_access();
      test_size_extremes();
      test_random_traffic();
      test_quiet_tail();
      repeat (20) @(posedge clock);
      if (pending_reads.size() != 0)
         $display("ERROR: %0d reads never answered", pending_reads.size());
      $display("Run covered %0d requests over %0d canvas sizes: %0d reads checked,",
               requests_sent, sizes_used, reads_checked);
      $display("  %0d fills, %0d clears, %0d errors", fills_sent, clears_sent,
               error_count);
      if (error_count == 0 && pending_reads.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, sweeps and fills included.
   initial begin
      #(40_000_000);
      $display("ERROR: timeout with %0d reads outstanding", pending_reads.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
